// ===== hdl/tcjs_pkg.sv =====
// Package with the shared types and constants of the two processor job scheduler.
`default_nettype none
package tcjs_pkg;
  localparam int MaxJobs  = 32;
  localparam int IdxW     = $clog2(MaxJobs);
  localparam int CntW     = $clog2(MaxJobs + 1);
  localparam int FracBits = 8;
  localparam int ClkW     = 22;
  localparam int TsumW    = 27;
  localparam int WsumW    = 35;
  localparam int W30      = 30;
  localparam int DivW     = ClkW + FracBits + 5;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_HRRN = 2'd2,
    POL_RSVD = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN,
    ST_SCAN_END,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_COMPUTE,
    ST_DIV_W,
    ST_ACCUM,
    ST_DIV_AT,
    ST_DIV_AW,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/two_cpu_job_scheduler.sv =====
// Top level of the two processor non-preemptive job scheduler.
// Usage: raise start for one cycle while busy is low with in_opcode and the
// job fields. A load stores one job (tag, arrival, run time) into the job
// memory unless it already holds 32 jobs; a clear empties it. A run schedules
// all loaded jobs on processors A and B and emits one result per job in
// dispatch order, each for one cycle with out_valid high; the receiver cannot
// hold results off. Each pick scans the job memory one entry per cycle, then
// fetches the chosen entry and divides the weighted turnaround on the shared
// serial divider; the last result adds two more divisions for the averages.
// The policy register is written through cfg_valid/cfg_ready while the block
// is idle. A run with no jobs emits a single result with last and empty flags.
// After reset the job count, clocks, sums and policy are zero and done flags
// are clear; the job memory holds nothing until written.
`default_nettype none
module two_cpu_job_scheduler
  import tcjs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [7:0]        in_job_tag,
  input  wire logic [15:0]       in_arrival_time,
  input  wire logic [15:0]       in_run_time,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_policy_mode,
  output logic                   out_valid,
  output logic [7:0]             out_result_tag,
  output logic                   out_cpu_used,
  output logic [ClkW-1:0]        out_start_time,
  output logic [ClkW-1:0]        out_finish_time,
  output logic [ClkW-1:0]        out_turnaround,
  output logic [W30-1:0]         out_weighted_turnaround,
  output logic [W30-1:0]         out_avg_turnaround,
  output logic [W30-1:0]         out_avg_weighted,
  output logic                   out_last_flag,
  output logic                   out_empty_flag
);
  localparam int EntW = 40;

  logic [EntW-1:0] job_mem [MaxJobs];
  logic [EntW-1:0] rd_data_r;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  state_t state_r, state_nxt;
  logic [1:0]      policy_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [MaxJobs-1:0] done_r, done_nxt;
  logic [ClkW-1:0] clk_a_r, clk_a_nxt, clk_b_r, clk_b_nxt;
  logic [TsumW-1:0] tsum_r, tsum_nxt;
  logic [WsumW-1:0] wsum_r, wsum_nxt;
  logic [CntW-1:0] scan_r, scan_nxt;
  logic [CntW-1:0] emitted_r, emitted_nxt;
  logic [IdxW-1:0] best_r, best_nxt;
  logic            have_r, have_nxt, have_rdy_r, have_rdy_nxt;
  logic [15:0]     best_arr_r, best_arr_nxt, best_need_r, best_need_nxt;
  logic [IdxW-1:0] early_r, early_nxt;
  logic [15:0]     early_arr_r, early_arr_nxt;
  logic [IdxW-1:0] cand_r;
  logic            cand_ok_r;
  logic [7:0]      tag_r, tag_nxt;
  logic [ClkW-1:0] start_r, start_nxt, fin_r, fin_nxt, turn_r, turn_nxt;
  logic [W30-1:0]  w_r, w_nxt, avg_t_r, avg_t_nxt;
  logic            use_b_r, use_b_nxt;
  logic [ClkW-1:0] tnow;
  policy_t         pol;
  div_req_t        dreq;
  div_rsp_t        drsp;

  logic [15:0]     c_arr, c_need;
  logic [ClkW-1:0] c_wait, b_wait;
  logic [ClkW:0]   num_c, num_b;
  logic [ClkW+16:0] prod_c, prod_b;
  logic            better;
  logic [ClkW:0]   fin_sum;
  logic [TsumW:0]  tsum_add;
  logic [WsumW:0]  wsum_add;

  assign pol  = (policy_r == POL_RSVD) ? POL_FCFS : policy_t'(policy_r);
  assign tnow = (clk_b_r < clk_a_r) ? clk_b_r : clk_a_r;
  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  tcjs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en) job_mem[wr_addr] <= wr_data;
    rd_data_r <= job_mem[rd_addr];
  end

  assign c_arr  = rd_data_r[31:16];
  assign c_need = rd_data_r[15:0];
  assign c_wait = tnow - ClkW'(c_arr);
  assign b_wait = tnow - ClkW'(best_arr_r);
  assign num_c  = {1'b0, c_wait} + (ClkW+1)'(c_need);
  assign num_b  = {1'b0, b_wait} + (ClkW+1)'(best_need_r);
  assign prod_c = (ClkW+17)'(num_c) * (ClkW+17)'(best_need_r);
  assign prod_b = (ClkW+17)'(num_b) * (ClkW+17)'(c_need);

  always_comb begin
    case (pol)
      POL_SJF:  better = c_need < best_need_r;
      POL_HRRN: better = prod_c > prod_b;
      default:  better = c_arr < best_arr_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(in_opcode))
            OP_LOAD:  state_nxt = ST_EMIT;
            OP_CLEAR: state_nxt = ST_EMIT;
            OP_RUN:   state_nxt = (count_r == '0) ? ST_EMPTY : ST_SCAN_REQ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_REQ:   state_nxt = ST_SCAN;
      ST_SCAN:       state_nxt = (scan_r == count_r) ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END:   state_nxt = ST_FETCH;
      ST_FETCH:      state_nxt = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_nxt = ST_COMPUTE;
      ST_COMPUTE:    state_nxt = ST_DIV_W;
      ST_DIV_W:      state_nxt = drsp.done ? ST_ACCUM : ST_DIV_W;
      ST_ACCUM:      state_nxt = (emitted_r + CntW'(1) == count_r) ? ST_DIV_AT : ST_EMIT;
      ST_DIV_AT:     state_nxt = drsp.done ? ST_DIV_AW : ST_DIV_AT;
      ST_DIV_AW:     state_nxt = drsp.done ? ST_EMIT : ST_DIV_AW;
      ST_EMIT: begin
        if (emitted_r == '0) state_nxt = ST_IDLE;
        else if (emitted_r == count_r) state_nxt = ST_IDLE;
        else state_nxt = ST_SCAN_REQ;
      end
      ST_EMPTY:      state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r; done_nxt = done_r; clk_a_nxt = clk_a_r; clk_b_nxt = clk_b_r;
    tsum_nxt = tsum_r; wsum_nxt = wsum_r; scan_nxt = scan_r; emitted_nxt = emitted_r;
    best_nxt = best_r; have_nxt = have_r; have_rdy_nxt = have_rdy_r;
    best_arr_nxt = best_arr_r; best_need_nxt = best_need_r;
    early_nxt = early_r; early_arr_nxt = early_arr_r;
    tag_nxt = tag_r; start_nxt = start_r;
    fin_nxt = fin_r; turn_nxt = turn_r; w_nxt = w_r; avg_t_nxt = avg_t_r;
    use_b_nxt = use_b_r;
    rd_addr = scan_r[IdxW-1:0];
    wr_en = 1'b0; wr_addr = count_r[IdxW-1:0];
    wr_data = {8'(in_job_tag), in_arrival_time,
               (in_run_time == 16'd0) ? 16'd1 : in_run_time};
    dreq = '0;
    fin_sum = '0; tsum_add = '0; wsum_add = '0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        emitted_nxt = '0;
        if (start) begin
          case (opcode_t'(in_opcode))
            OP_LOAD: begin
              if (count_r < CntW'(MaxJobs)) begin
                wr_en = 1'b1;
                done_nxt[count_r[IdxW-1:0]] = 1'b0;
                count_nxt = count_r + CntW'(1);
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              done_nxt = '0;
            end
            OP_RUN: begin
              done_nxt = '0; clk_a_nxt = '0; clk_b_nxt = '0;
              tsum_nxt = '0; wsum_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_REQ: begin
        rd_addr = '0;
        scan_nxt = CntW'(1);
        have_nxt = 1'b0; have_rdy_nxt = 1'b0;
      end
      ST_SCAN: begin
        rd_addr = scan_r[IdxW-1:0];
        if (cand_ok_r) begin
          if (!have_r || c_arr < early_arr_r) begin
            early_nxt = cand_r; early_arr_nxt = c_arr; have_nxt = 1'b1;
          end
          if (ClkW'(c_arr) <= tnow && (!have_rdy_r || better)) begin
            best_nxt = cand_r; best_arr_nxt = c_arr; best_need_nxt = c_need;
            have_rdy_nxt = 1'b1;
          end
        end
        if (scan_r != count_r) scan_nxt = scan_r + CntW'(1);
      end
      ST_SCAN_END: begin
        if (!have_rdy_r) best_nxt = early_r;
      end
      ST_FETCH: begin
        rd_addr = best_r;
      end
      ST_FETCH_WAIT: begin
        rd_addr = best_r;
      end
      ST_COMPUTE: begin
        tag_nxt = rd_data_r[39:32];
        use_b_nxt = clk_b_r < clk_a_r;
        start_nxt = (tnow < ClkW'(c_arr)) ? ClkW'(c_arr) : tnow;
        fin_sum = {1'b0, start_nxt} + (ClkW+1)'(c_need);
        fin_nxt = fin_sum[ClkW] ? {ClkW{1'b1}} : fin_sum[ClkW-1:0];
        turn_nxt = fin_nxt - ClkW'(c_arr);
        dreq.start = 1'b1;
        dreq.dividend = DivW'({turn_nxt, FracBits'(0)});
        dreq.divisor = DivW'(c_need);
        done_nxt[best_r] = 1'b1;
      end
      ST_DIV_W: begin
        if (drsp.done) begin
          w_nxt = (drsp.quotient > DivW'({W30{1'b1}})) ? {W30{1'b1}}
                                                         : drsp.quotient[W30-1:0];
        end
      end
      ST_ACCUM: begin
        if (use_b_r) clk_b_nxt = fin_r; else clk_a_nxt = fin_r;
        tsum_add = {1'b0, tsum_r} + (TsumW+1)'(turn_r);
        tsum_nxt = tsum_add[TsumW] ? {TsumW{1'b1}} : tsum_add[TsumW-1:0];
        wsum_add = {1'b0, wsum_r} + (WsumW+1)'(w_r);
        wsum_nxt = wsum_add[WsumW] ? {WsumW{1'b1}} : wsum_add[WsumW-1:0];
        emitted_nxt = emitted_r + CntW'(1);
        if (emitted_r + CntW'(1) == count_r) begin
          dreq.start = 1'b1;
          dreq.dividend = DivW'({tsum_nxt, FracBits'(0)});
          dreq.divisor = DivW'(count_r);
        end
      end
      ST_DIV_AT: begin
        if (drsp.done) begin
          avg_t_nxt = (drsp.quotient > DivW'({W30{1'b1}})) ? {W30{1'b1}}
                                                           : drsp.quotient[W30-1:0];
          dreq.start = 1'b1;
          dreq.dividend = wsum_r;
          dreq.divisor = DivW'(count_r);
        end
      end
      ST_DIV_AW: ;
      ST_EMIT: begin
        out_valid = (emitted_r != '0);
      end
      ST_EMPTY: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  logic last_emit;
  assign last_emit = (state_r == ST_EMIT) && (emitted_r == count_r);
  logic [W30-1:0] avg_w_sat;
  assign avg_w_sat = (drsp.quotient > DivW'({W30{1'b1}})) ? {W30{1'b1}}
                                                          : drsp.quotient[W30-1:0];
  logic [W30-1:0] avg_w_r;

  always_comb begin
    if (state_r == ST_EMPTY) begin
      out_result_tag = '0; out_cpu_used = 1'b0; out_start_time = '0;
      out_finish_time = '0; out_turnaround = '0; out_weighted_turnaround = '0;
      out_avg_turnaround = '0; out_avg_weighted = '0;
      out_last_flag = 1'b1; out_empty_flag = 1'b1;
    end else begin
      out_result_tag = tag_r; out_cpu_used = use_b_r; out_start_time = start_r;
      out_finish_time = fin_r; out_turnaround = turn_r; out_weighted_turnaround = w_r;
      out_avg_turnaround = last_emit ? avg_t_r : '0;
      out_avg_weighted = last_emit ? avg_w_r : '0;
      out_last_flag = last_emit; out_empty_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; policy_r <= '0; count_r <= '0; done_r <= '0;
      clk_a_r <= '0; clk_b_r <= '0; tsum_r <= '0; wsum_r <= '0;
      scan_r <= '0; emitted_r <= '0; have_r <= 1'b0; have_rdy_r <= 1'b0;
      cand_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) policy_r <= cfg_policy_mode;
      count_r <= count_nxt; done_r <= done_nxt;
      clk_a_r <= clk_a_nxt; clk_b_r <= clk_b_nxt;
      tsum_r <= tsum_nxt; wsum_r <= wsum_nxt;
      scan_r <= scan_nxt; emitted_r <= emitted_nxt;
      have_r <= have_nxt; have_rdy_r <= have_rdy_nxt;
      cand_ok_r <= ((state_r == ST_SCAN_REQ) ||
                    (state_r == ST_SCAN && scan_r != count_r)) &&
                   !done_r[rd_addr];
    end
    cand_r <= rd_addr;
    best_r <= best_nxt; best_arr_r <= best_arr_nxt; best_need_r <= best_need_nxt;
    early_r <= early_nxt; early_arr_r <= early_arr_nxt;
    tag_r <= tag_nxt;
    start_r <= start_nxt; fin_r <= fin_nxt; turn_r <= turn_nxt;
    w_r <= w_nxt; avg_t_r <= avg_t_nxt; use_b_r <= use_b_nxt;
    if (state_r == ST_DIV_AW && drsp.done) avg_w_r <= avg_w_sat;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an operation");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPUTE) |=> (state_r == ST_DIV_W))
    else $error("divide did not follow pick");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_empty_flag |-> out_last_flag)
    else $error("empty result not marked last");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CntW'(MaxJobs)))
    else $error("job count overflow");
endmodule
`default_nettype wire

// ===== hdl/tcjs_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tcjs_divider
  import tcjs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int StepW = $clog2(DivW + 1);

  logic [DivW-1:0]  quo_r, quo_nxt;
  logic [DivW:0]    rem_r, rem_nxt;
  logic [DivW-1:0]  den_r, den_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DivW:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DivW-1:0], quo_r[DivW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = StepW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - StepW'(1);
      if (cnt_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

// ===== test/tb_two_cpu_job_scheduler.sv =====
// Self-checking testbench for the two processor job scheduler: random job sets, all policies.
module tb_two_cpu_job_scheduler;
  import tcjs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {E_ITEM, E_CFG, E_SYNC} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    opcode_t     op;
    logic [7:0]  tag;
    logic [15:0] arr;
    logic [15:0] run;
    policy_t     pol;
    int          idle_pct;
  } pending_t;

  typedef struct {
    logic [7:0]     tag;
    logic           cpu;
    logic [ClkW-1:0] t_start;
    logic [ClkW-1:0] t_finish;
    logic [ClkW-1:0] turn;
    logic [W30-1:0] wturn;
    logic [W30-1:0] avg_t;
    logic [W30-1:0] avg_w;
    logic           last;
    logic           empty;
  } sched_result_t;

  localparam int SettleCycles = 40;
  localparam longint unsigned ClkMax  = (64'd1 << ClkW) - 1;
  localparam longint unsigned TsumMax = (64'd1 << TsumW) - 1;
  localparam longint unsigned WsumMax = (64'd1 << WsumW) - 1;
  localparam longint unsigned W30Max  = (64'd1 << W30) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = 2'd0;
  logic [7:0] in_job_tag = 8'd0;
  logic [15:0] in_arrival_time = 16'd0;
  logic [15:0] in_run_time = 16'd0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_policy_mode = 2'd0;
  logic out_valid;
  logic [7:0] out_result_tag;
  logic out_cpu_used;
  logic [ClkW-1:0] out_start_time, out_finish_time, out_turnaround;
  logic [W30-1:0] out_weighted_turnaround, out_avg_turnaround, out_avg_weighted;
  logic out_last_flag, out_empty_flag;

  two_cpu_job_scheduler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_job_tag(in_job_tag),
    .in_arrival_time(in_arrival_time), .in_run_time(in_run_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_policy_mode(cfg_policy_mode),
    .out_valid(out_valid), .out_result_tag(out_result_tag), .out_cpu_used(out_cpu_used),
    .out_start_time(out_start_time), .out_finish_time(out_finish_time),
    .out_turnaround(out_turnaround), .out_weighted_turnaround(out_weighted_turnaround),
    .out_avg_turnaround(out_avg_turnaround), .out_avg_weighted(out_avg_weighted),
    .out_last_flag(out_last_flag), .out_empty_flag(out_empty_flag)
  );

  always #10 clk = ~clk;

  pending_t pending_q[$];
  sched_result_t expected_q[$];
  int mismatches = 0;
  bit all_sent = 1'b0;
  int cur_idle = 0;
  int settle = 0;

  // Model state of the scheduler.
  logic [15:0] m_arr[MaxJobs];
  logic [15:0] m_need[MaxJobs];
  logic [7:0]  m_tag[MaxJobs];
  bit          m_done[MaxJobs];
  int          m_count = 0;
  policy_t     m_policy = POL_FCFS;

  function automatic bit ranks_higher(int c, int b, longint unsigned t, policy_t pol);
    longint unsigned nc, nb;
    nc = m_need[c];
    nb = m_need[b];
    if (pol == POL_SJF) return nc < nb;
    if (pol == POL_HRRN)
      return ((t - m_arr[c]) + nc) * nb > ((t - m_arr[b]) + nb) * nc;
    return m_arr[c] < m_arr[b];
  endfunction

  function automatic int choose_job(longint unsigned t, policy_t pol);
    int best;
    bit have;
    best = 0;
    have = 1'b0;
    for (int i = 0; i < m_count; i++) begin
      if (!m_done[i] && m_arr[i] <= t && (!have || ranks_higher(i, best, t, pol))) begin
        best = i;
        have = 1'b1;
      end
    end
    if (have) return best;
    for (int i = 0; i < m_count; i++) begin
      if (!m_done[i] && (!have || m_arr[i] < m_arr[best])) begin
        best = i;
        have = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic void schedule_jobs();
    longint unsigned clk_a, clk_b, t, st, fin, turn, w, tsum, wsum;
    bit use_b;
    int j;
    policy_t pol;
    sched_result_t r;
    if (m_count == 0) begin
      r = '{default: '0};
      r.last = 1'b1;
      r.empty = 1'b1;
      expected_q.push_back(r);
      return;
    end
    pol = (m_policy == POL_RSVD) ? POL_FCFS : m_policy;
    clk_a = 0;
    clk_b = 0;
    tsum = 0;
    wsum = 0;
    for (int i = 0; i < MaxJobs; i++) m_done[i] = 1'b0;
    for (int k = 0; k < m_count; k++) begin
      use_b = clk_b < clk_a;
      t = use_b ? clk_b : clk_a;
      j = choose_job(t, pol);
      st = (t < m_arr[j]) ? m_arr[j] : t;
      fin = st + m_need[j];
      if (fin > ClkMax) fin = ClkMax;
      turn = fin - m_arr[j];
      w = (turn << FracBits) / m_need[j];
      if (w > W30Max) w = W30Max;
      if (use_b) clk_b = fin;
      else clk_a = fin;
      m_done[j] = 1'b1;
      tsum = tsum + turn;
      if (tsum > TsumMax) tsum = TsumMax;
      wsum = wsum + w;
      if (wsum > WsumMax) wsum = WsumMax;
      r = '{default: '0};
      r.tag = m_tag[j];
      r.cpu = use_b;
      r.t_start = ClkW'(st);
      r.t_finish = ClkW'(fin);
      r.turn = ClkW'(turn);
      r.wturn = W30'(w);
      if (k + 1 == m_count) begin
        r.avg_t = W30'(((tsum << FracBits) / m_count > W30Max) ? W30Max
                                                               : (tsum << FracBits) / m_count);
        r.avg_w = W30'((wsum / m_count > W30Max) ? W30Max : wsum / m_count);
        r.last = 1'b1;
      end
      expected_q.push_back(r);
    end
  endfunction

  function automatic void apply_command(opcode_t op, logic [7:0] tag, logic [15:0] arr,
                                        logic [15:0] run);
    case (op)
      OP_LOAD: begin
        if (m_count < MaxJobs) begin
          m_tag[m_count] = tag;
          m_arr[m_count] = arr;
          m_need[m_count] = (run == 16'd0) ? 16'd1 : run;
          m_done[m_count] = 1'b0;
          m_count++;
        end
      end
      OP_CLEAR: begin
        m_count = 0;
        for (int i = 0; i < MaxJobs; i++) m_done[i] = 1'b0;
      end
      OP_RUN: schedule_jobs();
      default: ;
    endcase
  endfunction

  // Driver.
  always @(posedge clk) begin
    logic nxt_start, nxt_cfg;
    pending_t e;
    if (rst_n) begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        apply_command(opcode_t'(in_opcode), in_job_tag, in_arrival_time, in_run_time);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        m_policy = policy_t'(cfg_policy_mode);
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_q.size() != 0) begin
        e = pending_q[0];
        case (e.kind)
          E_SYNC: begin
            if (expected_q.size() == 0 && !busy && !start) begin
              if (settle < SettleCycles) settle++;
              else begin
                settle = 0;
                void'(pending_q.pop_front());
              end
            end
          end
          E_CFG: begin
            void'(pending_q.pop_front());
            cfg_policy_mode <= e.pol;
            nxt_cfg = 1'b1;
          end
          default: begin
            if ($urandom_range(99) >= e.idle_pct) begin
              void'(pending_q.pop_front());
              in_opcode <= e.op;
              in_job_tag <= e.tag;
              in_arrival_time <= e.arr;
              in_run_time <= e.run;
              nxt_start = 1'b1;
            end
          end
        endcase
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
      all_sent <= pending_q.size() == 0 && !nxt_start && !nxt_cfg;
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v, inout bit bad);
    if (exp_v != act_v) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("Mismatch in %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  // Monitor.
  always @(posedge clk) begin
    sched_result_t r;
    bit bad;
    if (rst_n && out_valid) begin
      bad = 1'b0;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("Unexpected result transaction, tag %0d", out_result_tag);
        mismatches++;
      end else begin
        r = expected_q.pop_front();
        check_field("result_tag", r.tag, out_result_tag, bad);
        check_field("cpu_used", r.cpu, out_cpu_used, bad);
        check_field("start_time", r.t_start, out_start_time, bad);
        check_field("finish_time", r.t_finish, out_finish_time, bad);
        check_field("turnaround", r.turn, out_turnaround, bad);
        check_field("weighted_turnaround", r.wturn, out_weighted_turnaround, bad);
        check_field("avg_turnaround", r.avg_t, out_avg_turnaround, bad);
        check_field("avg_weighted", r.avg_w, out_avg_weighted, bad);
        check_field("last_flag", r.last, out_last_flag, bad);
        check_field("empty_flag", r.empty, out_empty_flag, bad);
        if (bad) mismatches++;
      end
    end
  end

  task automatic push_cmd(opcode_t op, logic [7:0] tag, logic [15:0] arr, logic [15:0] run);
    pending_q.push_back('{E_ITEM, op, tag, arr, run, POL_FCFS, cur_idle});
  endtask

  task automatic push_policy(policy_t pol);
    pending_q.push_back('{E_SYNC, OP_NONE, 8'd0, 16'd0, 16'd0, POL_FCFS, 0});
    pending_q.push_back('{E_CFG, OP_NONE, 8'd0, 16'd0, 16'd0, pol, 0});
  endtask

  task automatic push_job_set();
    int k, r, span;
    r = $urandom_range(99);
    k = (r < 70) ? $urandom_range(8, 1) : (r < 95) ? $urandom_range(32, 9)
                                                   : $urandom_range(36, 33);
    span = $urandom_range(1) ? 65535 : $urandom_range(200, 4);
    if ($urandom_range(9) != 0) push_cmd(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(19) == 0)
        push_cmd(OP_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
      push_cmd(OP_LOAD, 8'($urandom), 16'($urandom_range(span)),
               $urandom_range(1) ? 16'($urandom_range(span)) : 16'($urandom));
    end
    push_cmd(OP_RUN, 8'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(7) == 0) push_cmd(OP_RUN, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int idle_sets[4] = '{0, 72, 0, 9};
    policy_t pols[4] = '{POL_SJF, POL_HRRN, POL_RSVD, POL_FCFS};
    int sent;
    push_cmd(OP_RUN, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_LOAD, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_LOAD, 8'd255, 16'd65535, 16'd65535);
    push_cmd(OP_LOAD, 8'hA5, 16'd0, 16'd1);
    push_cmd(OP_LOAD, 8'h5A, 16'd0, 16'd1);
    push_cmd(OP_LOAD, 8'd17, 16'd3, 16'd65535);
    push_cmd(OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_RUN, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_RUN, 8'd0, 16'd0, 16'd0);
    for (int p = 0; p < 3; p++) begin
      push_policy(pols[p]);
      push_cmd(OP_RUN, 8'd0, 16'd0, 16'd0);
    end
    push_cmd(OP_CLEAR, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_RUN, 8'd0, 16'd0, 16'd0);
    for (int ph = 0; ph < 4; ph++) begin
      cur_idle = idle_sets[ph];
      push_policy(pols[ph]);
      sent = pending_q.size();
      while (pending_q.size() - sent < 75) begin
        if ($urandom_range(5) == 0) push_policy(policy_t'($urandom_range(3)));
        push_job_set();
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (all_sent && expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/tcjs_pkg.sv
hdl/tcjs_divider.sv
hdl/two_cpu_job_scheduler.sv
test/tb_two_cpu_job_scheduler.sv
